// ===== hdl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// shared constants and types of the sliding window median filter
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_BITS        = 7;
    localparam int WIN_RESET       = 3;

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic step;  // insert the new sample, drop the oldest when full
        logic clr;   // empty the window
        logic full;  // window holds window_size samples before this step
    } t_cell_ctl;

endpackage

// ===== hdl/swm_cell.sv =====
// ----------------------------------------------------------------------------
// swm_cell
// one slot of the sorted window: removes the leaving sample and inserts the
// new one in a single step, looking only at its two neighbors
// ----------------------------------------------------------------------------
module swm_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int IW          = 6,
    parameter int IDX         = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  swm_pkg::t_cell_ctl            i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_leave,
    input  logic        [IW-1:0]          i_lo_idx,
    input  logic        [IW-1:0]          i_hi_idx,
    input  logic signed [SAMPLE_BITS-1:0] i_up_val,
    input  logic                          i_up_vld,
    output logic signed [SAMPLE_BITS-1:0] o_val,
    output logic                          o_vld,
    input  logic signed [SAMPLE_BITS-1:0] i_dn_u,
    input  logic                          i_dn_uv,
    output logic signed [SAMPLE_BITS-1:0] o_u,
    output logic                          o_uv,
    output logic        [SAMPLE_BITS-1:0] o_lo_tap,
    output logic        [SAMPLE_BITS-1:0] o_hi_tap
);
    import swm_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic signed [SAMPLE_BITS-1:0] r_val;
    logic signed [SAMPLE_BITS-1:0] n_val;
    logic                          r_vld;
    logic                          n_vld;
    logic                          w_ge;
    logic                          w_prev_gt;
    logic                          w_own_gt;

    // list after removal of the leaving sample
    always_comb begin
        w_ge = (r_val >= i_leave);
        o_u  = (i_ctl.full && w_ge) ? i_up_val : r_val;
        o_uv = i_ctl.full ? i_up_vld : r_vld;
    end

    // insertion into that list
    always_comb begin
        w_prev_gt = i_dn_uv && (i_dn_u > i_sample);
        w_own_gt  = (o_u > i_sample);
        if (w_prev_gt) begin
            n_val = i_dn_u;
        end else if (!o_uv || w_own_gt) begin
            n_val = i_sample;
        end else begin
            n_val = o_u;
        end
        n_vld = o_uv | i_dn_uv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.clr) begin
            r_vld <= 1'b0;
        end else if (i_ctl.step) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_val <= n_val;
        end
    end

    assign o_val    = r_val;
    assign o_vld    = r_vld;
    assign o_lo_tap = (i_lo_idx == MY_IDX) ? r_val : '0;
    assign o_hi_tap = (i_hi_idx == MY_IDX) ? r_val : '0;

endmodule

// ===== hdl/sliding_window_median_core.sv =====
// ----------------------------------------------------------------------------
// sliding_window_median_core
// sliding window median filter: a sorted row of cells plus a sample ring,
// gives twice the window median once the window is full
//
//   channel   dir  handshake                      contents
//   s_axis    in   s_axis_tvalid/s_axis_tready    sample
//   m_axis    out  m_axis_tvalid/m_axis_tready    median_x2
//   cfg       in   i_cfg_wr_en                    window_size
//
// a new sample is not accepted before the next ring read has settled: the cell
// row updates at the accepting edge, then the ring reads the next oldest sample at the new pointer
// the median is registered from the cell row once the output register is free, and held until taken
// a sample is accepted while a result waits, but not while one is still
// being formed; synchronous active-low reset empties the window
// ----------------------------------------------------------------------------
module sliding_window_median_core #(
    parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [SAMPLE_BITS-1:0] sample, rest zero
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]         s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // [SAMPLE_BITS:0] median_x2, rest zero
    output logic [((SAMPLE_BITS+8)/8)*8-1:0]         m_axis_tdata,
    input  logic                                     i_cfg_wr_en,
    input  logic [swm_pkg::CFG_BITS-1:0]             i_cfg_wr_data
);
    import swm_pkg::*;

    localparam int IW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW      = $clog2(MAX_WINDOW + 1);
    localparam int EW      = (CW > CFG_BITS) ? CW : CFG_BITS;
    localparam int OW      = SAMPLE_BITS + 1;
    localparam int ODW     = ((SAMPLE_BITS + 8) / 8) * 8;
    localparam int WIN_RST = (WIN_RESET > MAX_WINDOW) ? MAX_WINDOW : WIN_RESET;

    logic [CW-1:0]                 r_win;
    logic [CW-1:0]                 r_fill;
    logic [IW-1:0]                 r_ptr;
    logic [IW-1:0]                 n_ptr;
    logic                          r_hold;
    logic                          r_pend;
    logic                          r_ovld;
    logic [OW-1:0]                 r_med;
    logic signed [SAMPLE_BITS-1:0] r_leave;
    logic [SAMPLE_BITS-1:0]        r_ring [MAX_WINDOW];

    logic                          w_acc;
    logic                          w_ld;
    logic                          w_full;
    logic                          w_emit;
    logic [EW-1:0]                 w_cfg;
    logic [CW-1:0]                 w_cfg_win;
    logic [CW:0]                   w_ptr_inc;
    logic [CW-1:0]                 w_half;
    logic [IW-1:0]                 w_lo_idx;
    logic [IW-1:0]                 w_hi_idx;
    logic signed [SAMPLE_BITS-1:0] w_sample;
    t_cell_ctl                     w_ctl;

    logic signed [SAMPLE_BITS-1:0] w_val [MAX_WINDOW+1];
    logic                          w_vld [MAX_WINDOW+1];
    logic signed [SAMPLE_BITS-1:0] w_u   [MAX_WINDOW+1];
    logic                          w_uv  [MAX_WINDOW+1];
    logic [SAMPLE_BITS-1:0]        w_lo_tap [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0]        w_hi_tap [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0]        w_lo;
    logic [SAMPLE_BITS-1:0]        w_hi;

    assign w_sample      = s_axis_tdata[SAMPLE_BITS-1:0];
    assign s_axis_tready = !r_hold && !r_pend;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_ld          = r_pend && (!r_ovld || m_axis_tready);
    assign w_full        = (r_fill >= r_win);
    assign w_emit        = w_full || ((r_fill + 1'b1) == r_win);

    // window size clamp
    always_comb begin
        w_cfg = EW'(i_cfg_wr_data);
        if (w_cfg == '0) begin
            w_cfg_win = CW'(1);
        end else if (w_cfg > EW'(MAX_WINDOW)) begin
            w_cfg_win = CW'(MAX_WINDOW);
        end else begin
            w_cfg_win = CW'(w_cfg);
        end
    end

    always_comb begin
        w_ptr_inc = {1'b0, CW'(r_ptr)} + 1'b1;
        n_ptr     = (w_ptr_inc >= {1'b0, r_win}) ? '0 : IW'(w_ptr_inc);
        w_half    = r_win >> 1;
        w_hi_idx  = IW'(w_half);
        w_lo_idx  = r_win[0] ? IW'(w_half) : IW'(w_half - 1'b1);
    end

    always_comb begin
        w_ctl.step = w_acc;
        w_ctl.clr  = i_cfg_wr_en;
        w_ctl.full = w_full;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= CW'(WIN_RST);
            r_fill <= '0;
            r_ptr  <= '0;
            r_hold <= 1'b0;
            r_pend <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            r_hold <= w_acc || i_cfg_wr_en;
            if (i_cfg_wr_en) begin
                r_win  <= w_cfg_win;
                r_fill <= '0;
                r_ptr  <= '0;
            end else if (w_acc) begin
                r_ptr <= n_ptr;
                if (!w_full) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (w_acc) begin
                r_pend <= w_emit;
            end else if (w_ld) begin
                r_pend <= 1'b0;
            end
            if (w_ld) begin
                r_ovld <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // sample ring, registered read of the oldest slot
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ring[r_ptr] <= w_sample;
        end
        r_leave <= r_ring[r_ptr];
    end

    // sorted cell row
    assign w_val[MAX_WINDOW] = '0;
    assign w_vld[MAX_WINDOW] = 1'b0;
    assign w_u[0]            = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    assign w_uv[0]           = 1'b1;

    for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
        swm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .IW          (IW),
            .IDX         (k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_sample (w_sample),
            .i_leave  (r_leave),
            .i_lo_idx (w_lo_idx),
            .i_hi_idx (w_hi_idx),
            .i_up_val (w_val[k+1]),
            .i_up_vld (w_vld[k+1]),
            .o_val    (w_val[k]),
            .o_vld    (w_vld[k]),
            .i_dn_u   (w_u[k]),
            .i_dn_uv  (w_uv[k]),
            .o_u      (w_u[k+1]),
            .o_uv     (w_uv[k+1]),
            .o_lo_tap (w_lo_tap[k]),
            .o_hi_tap (w_hi_tap[k])
        );
    end

    // middle entries
    always_comb begin
        w_lo = '0;
        w_hi = '0;
        for (int k = 0; k < MAX_WINDOW; k++) begin
            w_lo = w_lo | w_lo_tap[k];
            w_hi = w_hi | w_hi_tap[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            r_med <= {w_lo[SAMPLE_BITS-1], w_lo} + {w_hi[SAMPLE_BITS-1], w_hi};
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = ODW'(r_med);

    // checks
    a_fill_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_win)
        else $error("fill count beyond window");

    a_ptr_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, CW'(r_ptr)} < {1'b0, r_win})
        else $error("ring pointer beyond window");

    a_full_emits : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_full) |=> r_pend)
        else $error("full window transaction gave no result");

    a_gap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> !s_axis_tready)
        else $error("transaction taken before ring read settled");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sliding window median filter: a queue-fed
// sample driver, a result monitor with random stalls, and an in-bench window
// predictor that keeps its own sample ring and sorted copy to compute twice
// the median for every sample once the window is full; window sizes are swept
// from the degenerate and saturating codes to random ones
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAX_WIN   = swm_pkg::MAX_WINDOW_DEF;
    localparam int SAMPLE_W  = swm_pkg::SAMPLE_BITS_DEF;
    localparam int MEDIAN_W  = SAMPLE_W + 1;
    localparam int IN_BUS_W  = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_BUS_W = ((SAMPLE_W + 8) / 8) * 8;
    localparam int ITEM_GOAL = 1850;
    localparam int SETTLE_CYC = 8;
    localparam int STALL_LIMIT = 4000;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [IN_BUS_W-1:0]          s_axis_tdata = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [OUT_BUS_W-1:0]         m_axis_tdata;
    logic                         i_cfg_wr_en = 1'b0;
    logic [swm_pkg::CFG_BITS-1:0] i_cfg_wr_data = '0;

    // window predictor state
    logic signed [SAMPLE_W-1:0] ring_mem [MAX_WIN];
    logic signed [SAMPLE_W-1:0] sorted_mem [MAX_WIN];
    int                         fill_n = 0;
    int                         oldest_idx = 0;
    logic [swm_pkg::CFG_BITS-1:0] win_reg = swm_pkg::CFG_BITS'(swm_pkg::WIN_RESET);

    logic [SAMPLE_W-1:0] sample_q [$];
    logic [MEDIAN_W-1:0] median_q [$];

    logic [SAMPLE_W-1:0] corner_w3 [17] = '{
        16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001, 16'h8000,
        16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0005, 16'h0005,
        16'h0005, 16'h5555, 16'haaaa, 16'hfffe, 16'h0002
    };
    logic [SAMPLE_W-1:0] corner_w2 [6] = '{
        16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff
    };
    logic [swm_pkg::CFG_BITS-1:0] sweep_w [10] = '{
        7'd0, 7'd1, 7'd2, 7'd64, 7'd127, 7'd65, 7'd5, 7'd4, 7'd126, 7'd63
    };

    int send_idle_max = 5;
    int recv_idle_max = 5;
    int send_wait = 0;
    int recv_wait = 0;
    int err_cnt = 0;
    int pushed_cnt = 0;
    int stall_cnt = 0;
    int cluster_base = 0;

    sliding_window_median_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int eff_window();
        if (win_reg == 0) return 1;
        if (win_reg > MAX_WIN) return MAX_WIN;
        return int'(win_reg);
    endfunction

    task automatic window_step(input logic signed [SAMPLE_W-1:0] smp);
        int w;
        int i;
        int lo_v;
        int hi_v;
        logic signed [SAMPLE_W-1:0] gone;
        w = eff_window();
        if (oldest_idx >= w) oldest_idx = 0;
        if (fill_n >= w) begin
            gone = ring_mem[oldest_idx];
            i = 0;
            while (i < fill_n && sorted_mem[i] != gone) i++;
            if (i < fill_n) begin
                while (i + 1 < fill_n) begin
                    sorted_mem[i] = sorted_mem[i + 1];
                    i++;
                end
                fill_n--;
            end
        end
        if (fill_n < MAX_WIN) begin
            i = fill_n;
            while (i > 0 && sorted_mem[i - 1] > smp) begin
                sorted_mem[i] = sorted_mem[i - 1];
                i--;
            end
            sorted_mem[i] = smp;
            fill_n++;
        end
        ring_mem[oldest_idx] = smp;
        oldest_idx++;
        if (oldest_idx >= w) oldest_idx = 0;
        if (fill_n >= w) begin
            if (w % 2 == 1) begin
                lo_v = sorted_mem[w / 2];
                hi_v = lo_v;
            end else begin
                lo_v = sorted_mem[w / 2 - 1];
                hi_v = sorted_mem[w / 2];
            end
            median_q.insert(median_q.size(), MEDIAN_W'(lo_v + hi_v));
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return SAMPLE_W'($urandom);
        if (pick < 8) return SAMPLE_W'(cluster_base + int'($urandom_range(0, 6)) - 3);
        case ($urandom_range(0, 3))
            0: return {1'b1, {(SAMPLE_W-1){1'b0}}};
            1: return {1'b0, {(SAMPLE_W-1){1'b1}}};
            2: return '0;
            default: return '1;
        endcase
    endfunction

    task automatic queue_random(input int n);
        @(negedge i_clk);
        repeat (n) sample_q.insert(sample_q.size(), rand_sample());
        pushed_cnt += n;
    endtask

    task automatic drain();
        while (sample_q.size() != 0 || s_axis_tvalid || median_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_window(input logic [swm_pkg::CFG_BITS-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        win_reg    = val;
        fill_n     = 0;
        oldest_idx = 0;
    endtask

    always @(posedge i_clk) begin : sample_driver
        logic valid_nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_wait = 0;
        end else begin
            valid_nxt = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                window_step(s_axis_tdata[SAMPLE_W-1:0]);
                valid_nxt = 1'b0;
            end
            if (!valid_nxt && sample_q.size() > 0) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else begin
                    s_axis_tdata <= IN_BUS_W'(sample_q.pop_front());
                    valid_nxt = 1'b1;
                    send_wait = $urandom_range(0, send_idle_max);
                end
            end
            s_axis_tvalid <= valid_nxt;
        end
    end

    always @(posedge i_clk) begin : median_monitor
        logic [MEDIAN_W-1:0] want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (median_q.size() == 0) begin
                    $error("median_x2: unexpected transaction, actual %0d",
                           $signed(m_axis_tdata[MEDIAN_W-1:0]));
                    err_cnt++;
                end else begin
                    want = median_q.pop_front();
                    if (m_axis_tdata[MEDIAN_W-1:0] !== want) begin
                        $error("median_x2 mismatch: expected %0d, actual %0d",
                               $signed(want), $signed(m_axis_tdata[MEDIAN_W-1:0]));
                        err_cnt++;
                    end
                end
                recv_wait = $urandom_range(0, recv_idle_max);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || i_cfg_wr_en) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin : stimulus
        int n;
        int k;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset window of three, with a full pause partway through
        @(negedge i_clk);
        for (k = 0; k < 8; k++) sample_q.insert(sample_q.size(), corner_w3[k]);
        drain();
        for (k = 8; k < 17; k++) sample_q.insert(sample_q.size(), corner_w3[k]);
        pushed_cnt += 17;
        drain();

        write_window(7'd2);
        @(negedge i_clk);
        foreach (corner_w2[j]) sample_q.insert(sample_q.size(), corner_w2[j]);
        pushed_cnt += 6;
        drain();

        k = 0;
        while (pushed_cnt < ITEM_GOAL) begin
            if (k < 10) write_window(sweep_w[k]);
            else if (k % 3 == 0) write_window(swm_pkg::CFG_BITS'($urandom_range(0, 127)));
            else write_window(swm_pkg::CFG_BITS'($urandom_range(1, 9)));
            k++;
            send_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
            recv_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
            cluster_base  = $urandom_range(0, 65535) - 32768;
            n = eff_window() - 1 + $urandom_range(60, 140);
            if ($urandom_range(0, 2) == 0) begin
                queue_random(n / 2);
                drain();
                queue_random(n - n / 2);
            end else begin
                queue_random(n);
            end
            drain();
        end

        repeat (20) @(negedge i_clk);
        if (err_cnt == 0 && median_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/swm_pkg.sv
hdl/swm_cell.sv
hdl/sliding_window_median_core.sv
bench/tb_top.sv
